// ----- rtl/pproj_pkg.sv -----
package pproj_pkg;

  localparam int unsigned MaxDimDefault   = 4096;
  localparam int unsigned FracBitsDefault = 16;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned ReflW   = 16;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DimRegW = 13;
  localparam int unsigned PixW    = 12;
  localparam int unsigned OffW    = 26;
  localparam int unsigned NumCoefRegs = 6;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegRow0C01 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow0C23 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow1C01 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow1C23 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRow2C01 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRow2C23 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWidth   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegHeight  = 3'd7;

  localparam logic [DimRegW-1:0] WidthReset  = 13'd1242;
  localparam logic [DimRegW-1:0] HeightReset = 13'd375;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic        [ReflW-1:0]  reflectance;
  } point_t;

  typedef struct packed {
    logic            hit;
    logic [PixW-1:0] column;
    logic [PixW-1:0] row;
    logic [OffW-1:0] byte_offset;
  } pixel_t;

endpackage

// ----- rtl/pproj_if.sv -----
interface pproj_point_if;
  logic                 valid;
  logic                 ready;
  pproj_pkg::point_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pproj_pixel_if;
  logic                 valid;
  logic                 ready;
  pproj_pkg::pixel_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/point_to_pixel_projection_top.sv -----
// Point-to-pixel projection.
// Channels: point_if (sink) carries one lidar point per transaction; pixel_if
// (source) returns exactly one result per point, in order. A result has
// hit=1 with column, row and the byte offset of the 3-byte pixel, or all zero.
// The configuration port writes the six 3x4 matrix coefficient pairs and the
// image size; the user must use it only while the pipeline is empty, as the
// block itself does not enforce this. Throughput: one point per cycle while
// the output is not stalled. Stages, in order: one product stage, one
// floor-and-sum stage, one divider setup stage, one stage per quotient bit
// (log2(MAX_DIM) + 1) of the two parallel dividers, one check stage and the
// output register, which also forms the byte offset.
// Stall: the whole pipeline advances only when the output register is empty
// or being taken, so ready follows the receiver with no loss or repetition.
// Reset clears every valid bit and loads the reset matrix (zero) and image
// size 1242 x 375; the block accepts points in the first cycle after reset.
module point_to_pixel_projection_top #(
  parameter int unsigned MAX_DIM   = pproj_pkg::MaxDimDefault,
  parameter int unsigned FRAC_BITS = pproj_pkg::FracBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pproj_point_if.sink                     point_if,
  pproj_pixel_if.source                   pixel_if,
  input  logic                            cfg_we_i,
  input  logic [pproj_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pproj_pkg::CfgW-1:0]      cfg_data_i
);
  localparam int unsigned CW  = pproj_pkg::CoordW;
  localparam int unsigned PW  = 2 * CW;         // exact product
  localparam int unsigned SW  = PW - FRAC_BITS + 3; // sum of 3 floored + coef
  localparam int unsigned DW  = $clog2(MAX_DIM) + 1; // clamped dimension
  localparam int unsigned QW  = $clog2(MAX_DIM);     // quotient bits kept
  localparam int unsigned NW  = SW + 2;              // 2p + p2

  // Configuration registers.
  logic [pproj_pkg::CfgW-1:0]    coef_q [pproj_pkg::NumCoefRegs];
  logic [pproj_pkg::DimRegW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pproj_pkg::NumCoefRegs; i++) coef_q[i] <= '0;
      width_q  <= pproj_pkg::WidthReset;
      height_q <= pproj_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pproj_pkg::RegRow0C01: coef_q[0] <= cfg_data_i;
        pproj_pkg::RegRow0C23: coef_q[1] <= cfg_data_i;
        pproj_pkg::RegRow1C01: coef_q[2] <= cfg_data_i;
        pproj_pkg::RegRow1C23: coef_q[3] <= cfg_data_i;
        pproj_pkg::RegRow2C01: coef_q[4] <= cfg_data_i;
        pproj_pkg::RegRow2C23: coef_q[5] <= cfg_data_i;
        pproj_pkg::RegWidth:   width_q   <= cfg_data_i[pproj_pkg::DimRegW-1:0];
        pproj_pkg::RegHeight:  height_q  <= cfg_data_i[pproj_pkg::DimRegW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped image size.
  logic [DW-1:0] wdim, hdim;
  assign wdim = (32'(width_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(width_q);
  assign hdim = (32'(height_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(height_q);

  // Global advance: the output register is free or being drained.
  logic out_vld_q, adv;
  assign adv = !out_vld_q || pixel_if.ready;
  assign point_if.ready = adv;

  // Stage 1: nine 32x32 products.
  logic              v1_q;
  logic signed [PW-1:0] prod_q [3][3];
  logic              refl1_q;
  logic signed [CW-1:0] crd [3];
  assign crd[0] = point_if.payload.point_x;
  assign crd[1] = point_if.payload.point_y;
  assign crd[2] = point_if.payload.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= point_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      refl1_q <= point_if.payload.reflectance != '0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= PW'($signed(((k & 1) != 0) ? coef_q[2*r + k/2][63:32]
                                                      : coef_q[2*r + k/2][31:0]))
                          * PW'(crd[k]);
        end
      end
    end
  end

  // Stage 2: floor (arithmetic shift) and sum each row.
  logic              v2_q, refl2_q;
  logic signed [SW-1:0] p_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      refl2_q <= refl1_q;
      for (int r = 0; r < 3; r++) begin
        p_q[r] <= SW'(prod_q[r][0] >>> FRAC_BITS) + SW'(prod_q[r][1] >>> FRAC_BITS)
                + SW'(prod_q[r][2] >>> FRAC_BITS)
                + SW'($signed(coef_q[2*r+1][63:32]));
      end
    end
  end

  // Stage 3: divider operands (2p + p2) over 2 p2.
  logic signed [NW-1:0] nu, nv, dd;
  assign nu = (NW'(p_q[0]) <<< 1) + NW'(p_q[2]);
  assign nv = (NW'(p_q[1]) <<< 1) + NW'(p_q[2]);
  assign dd = NW'(p_q[2]) <<< 1;

  logic ok2;
  assign ok2 = refl2_q && (p_q[2] != '0) && !p_q[0][SW-1];

  logic          vu, vv, neg_u, neg_v, ovf_u, ovf_v;
  logic [QW:0]   mag_u, mag_v;
  logic [0:0]    side_u, side_v;

  pproj_div #(.NumW(NW), .DenW(NW), .QW(QW), .SideW(1)) u_div_u (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q), .num_i(nu), .den_i(dd),
    .side_i(ok2), .valid_o(vu), .mag_o(mag_u), .neg_o(neg_u), .ovf_o(ovf_u),
    .side_o(side_u)
  );
  pproj_div #(.NumW(NW), .DenW(NW), .QW(QW), .SideW(1)) u_div_v (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q), .num_i(nv), .den_i(dd),
    .side_i(ok2), .valid_o(vv), .mag_o(mag_v), .neg_o(neg_v), .ovf_o(ovf_v),
    .side_o(side_v)
  );

  // Check stage: a negative quotient is a miss unless its magnitude is zero.
  logic            v5_q, hit5_q;
  logic [QW-1:0]   u5_q, v5c_q;
  logic [DW-1:0]   w5_q;
  logic in_u, in_v;
  assign in_u = !ovf_u && (!neg_u || mag_u == '0) && ({1'b0, mag_u} < (QW+2)'(wdim));
  assign in_v = !ovf_v && (!neg_v || mag_v == '0) && ({1'b0, mag_v} < (QW+2)'(hdim));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= vu && vv;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit5_q <= side_u[0] && side_v[0] && in_u && in_v;
      u5_q   <= mag_u[QW-1:0];
      v5c_q  <= mag_v[QW-1:0];
      w5_q   <= wdim;
    end
  end

  // Output register: byte offset = 3 * (v * w + u).
  pproj_pkg::pixel_t out_q;
  logic [2*DW+1:0] lin;
  assign lin = (2*DW+2)'(v5c_q) * (2*DW+2)'(w5_q) + (2*DW+2)'(u5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.hit         <= hit5_q;
      out_q.column      <= hit5_q ? pproj_pkg::PixW'(u5_q) : '0;
      out_q.row         <= hit5_q ? pproj_pkg::PixW'(v5c_q) : '0;
      out_q.byte_offset <= hit5_q ? pproj_pkg::OffW'(lin * 3) : '0;
    end
  end

  assign pixel_if.valid   = out_vld_q;
  assign pixel_if.payload = out_q;
endmodule

// ----- rtl/pproj_div.sv -----
// Pipelined signed restoring divider: one quotient bit per stage, truncated
// toward zero. A side word travels along with each quotient.
module pproj_div #(
  parameter int unsigned NumW  = 70,
  parameter int unsigned DenW  = 68,
  parameter int unsigned QW    = 16,
  parameter int unsigned SideW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic [QW:0]            mag_o,
  output logic                   neg_o,
  output logic                   ovf_o,
  output logic [SideW-1:0]       side_o
);
  // Magnitudes. Quotient overflow is flagged: ovf when |num| >= |den| << (QW + 1).
  localparam int unsigned MagW = NumW;
  localparam int unsigned Stg  = QW + 1;

  logic [MagW-1:0]  nmag, dmag;
  logic [MagW-1:0]  rem_q  [Stg+1];
  logic [MagW-1:0]  den_q  [Stg+1];
  logic [QW:0]      quo_q  [Stg+1];
  logic             neg_q  [Stg+1];
  logic             ovf_q  [Stg+1];
  logic             vld_q  [Stg+1];
  logic [SideW-1:0] side_q [Stg+1];
  logic [MagW+QW+1:0] big_d;

  assign nmag  = num_i[NumW-1] ? MagW'(-num_i) : MagW'(num_i);
  assign dmag  = den_i[DenW-1] ? MagW'(-(NumW'(den_i))) : MagW'(NumW'(den_i));
  assign big_d = {(QW+2)'(0), dmag} << Stg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= nmag;
      den_q[0]  <= dmag;
      quo_q[0]  <= '0;
      neg_q[0]  <= num_i[NumW-1] ^ den_i[DenW-1];
      ovf_q[0]  <= {(QW+2)'(0), nmag} >= big_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < Stg; s++) begin : g_stage
    localparam int unsigned Sh = Stg - 1 - s;
    logic [MagW+QW:0] dsh;
    logic             ge;
    assign dsh = {(QW+1)'(0), den_q[s]} << Sh;
    assign ge  = {(QW+1)'(0), rem_q[s]} >= dsh;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? rem_q[s] - MagW'(dsh) : rem_q[s];
        den_q[s+1]  <= den_q[s];
        quo_q[s+1]  <= {quo_q[s][QW-1:0], ge};
        neg_q[s+1]  <= neg_q[s];
        ovf_q[s+1]  <= ovf_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[Stg];
  assign mag_o   = quo_q[Stg];
  assign neg_o   = neg_q[Stg];
  assign ovf_o   = ovf_q[Stg];
  assign side_o  = side_q[Stg];
endmodule

// ----- rtl/pproj_checker.sv -----
module pproj_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input pproj_pkg::pixel_t out_payload_i
);
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_payload_i.hit |-> out_payload_i.byte_offset == '0 &&
    out_payload_i.column == '0 && out_payload_i.row == '0) else $error("miss not zero");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("ready dropped with empty output");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled result changed");
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i) else $error("accept during stall");
endmodule

bind point_to_pixel_projection_top pproj_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(point_if.valid), .in_ready_i(point_if.ready),
  .out_valid_i(pixel_if.valid), .out_ready_i(pixel_if.ready),
  .out_payload_i(pixel_if.payload)
);

// ----- sim/point_to_pixel_projection_top_tb.sv -----
`timescale 1ns / 1ps

module point_to_pixel_projection_top_tb;

  // Extra wait after the last outstanding result has been checked.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomPoints = 1950;

  // Scoreboard: predicts the pixel for each accepted point and checks results in order.
  class pixel_scoreboard;
    logic [pproj_pkg::CfgW-1:0] coef_reg [pproj_pkg::NumCoefRegs];
    logic [pproj_pkg::DimRegW-1:0] width_reg;
    logic [pproj_pkg::DimRegW-1:0] height_reg;
    pproj_pkg::pixel_t pending_pixels [$];
    int unsigned mismatches;

    function new();
      foreach (coef_reg[i]) coef_reg[i] = '0;
      width_reg = pproj_pkg::WidthReset;
      height_reg = pproj_pkg::HeightReset;
      mismatches = 0;
    endfunction

    function void write_reg(logic [pproj_pkg::CfgIdxW-1:0] idx,
                            logic [pproj_pkg::CfgW-1:0] data);
      if (idx == pproj_pkg::RegWidth) begin
        width_reg = data[pproj_pkg::DimRegW-1:0];
      end else if (idx == pproj_pkg::RegHeight) begin
        height_reg = data[pproj_pkg::DimRegW-1:0];
      end else begin
        coef_reg[idx] = data;
      end
    endfunction

    function longint coef_of(int r, int k);
      logic [pproj_pkg::CfgW-1:0] w;
      w = coef_reg[r * 2 + k / 2];
      return (k % 2) ? longint'(signed'(w[63:32])) : longint'(signed'(w[31:0]));
    endfunction

    // The arithmetic shift floors, matching rounding toward minus infinity.
    function longint matrix_row(int r, longint x, longint y, longint z);
      return ((coef_of(r, 0) * x) >>> pproj_pkg::FracBitsDefault) +
             ((coef_of(r, 1) * y) >>> pproj_pkg::FracBitsDefault) +
             ((coef_of(r, 2) * z) >>> pproj_pkg::FracBitsDefault) + coef_of(r, 3);
    endfunction

    function void note_point(pproj_pkg::point_t pt);
      longint p0, p1, p2, u, v, w, h;
      logic [63:0] offs;
      pproj_pkg::pixel_t px;
      p0 = matrix_row(0, pt.point_x, pt.point_y, pt.point_z);
      p1 = matrix_row(1, pt.point_x, pt.point_y, pt.point_z);
      p2 = matrix_row(2, pt.point_x, pt.point_y, pt.point_z);
      w = (width_reg > pproj_pkg::MaxDimDefault) ? pproj_pkg::MaxDimDefault : width_reg;
      h = (height_reg > pproj_pkg::MaxDimDefault) ? pproj_pkg::MaxDimDefault : height_reg;
      px = '0;
      if (p2 != 0) begin
        u = (2 * p0 + p2) / (2 * p2);
        v = (2 * p1 + p2) / (2 * p2);
        if (p0 >= 0 && u >= 0 && u < w && v >= 0 && v < h && pt.reflectance != 0) begin
          offs = v * w * 3 + u * 3;
          px.hit = 1'b1;
          px.column = u[pproj_pkg::PixW-1:0];
          px.row = v[pproj_pkg::PixW-1:0];
          px.byte_offset = offs[pproj_pkg::OffW-1:0];
        end
      end
      pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    function void check_pixel(pproj_pkg::pixel_t got);
      pproj_pkg::pixel_t exp_px;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        mismatches++;
        return;
      end
      exp_px = pending_pixels.pop_front();
      if (got.hit !== exp_px.hit || got.column !== exp_px.column ||
          got.row !== exp_px.row || got.byte_offset !== exp_px.byte_offset) begin
        $display("%0t: expected hit=%0d col=%0d row=%0d off=%0d,",
                 $time, exp_px.hit, exp_px.column, exp_px.row, exp_px.byte_offset,
                 " got hit=%0d col=%0d row=%0d off=%0d",
                 got.hit, got.column, got.row, got.byte_offset);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pproj_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [pproj_pkg::CfgW-1:0] cfg_data_i = '0;

  pproj_point_if point_if ();
  pproj_pixel_if pixel_if ();

  pixel_scoreboard pixel_sb = new();
  int unsigned idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    point_if.valid = 1'b0;
    point_if.payload = '0;
    pixel_if.ready = 1'b0;
  end

  point_to_pixel_projection_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .point_if   (point_if.sink),
    .pixel_if   (pixel_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // After each result it takes, the receiver may stall before the next one; some stretches never stall.
  // Every accepted result transaction is checked against the oldest prediction.
  int unsigned sink_wait = 0;
  bit sink_busy_phase = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pixel_if.valid && pixel_if.ready) begin
        pixel_sb.check_pixel(pixel_if.payload);
        sink_wait = sink_busy_phase ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 99) == 0) sink_busy_phase = ~sink_busy_phase;
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      pixel_if.ready <= (sink_wait == 0);
    end
  end

  // The watchdog counts cycles without any transaction on either channel.
  always @(posedge clk_i) begin
    if ((point_if.valid && point_if.ready) || (pixel_if.valid && pixel_if.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("point_to_pixel_projection_top_tb failed");
        $finish;
      end
    end
  end

  // Writes one register; called only while the pipeline is empty.
  task automatic write_reg(logic [pproj_pkg::CfgIdxW-1:0] idx,
                           logic [pproj_pkg::CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pixel_sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Presents one point, after a random gap unless no_gap is set, and holds it until the transaction happens.
  task automatic send_point(pproj_pkg::point_t pt, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      point_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_if.valid <= 1'b1;
    point_if.payload <= pt;
    @(posedge clk_i);
    while (!point_if.ready) @(posedge clk_i);
    pixel_sb.note_point(pt);
  endtask

  // Lets every outstanding result drain, then waits DrainCycles more cycles for good measure.
  task automatic drain_pipeline();
    point_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pixel_sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [pproj_pkg::CfgW-1:0] coef_pair(int lo_q, int hi_q);
    return {hi_q[31:0], lo_q[31:0]};
  endfunction

  // A camera-like matrix: focal length, principal point and a depth row built from z.
  task automatic load_camera(int f, int cx, int cy, bit flip_depth);
    write_reg(pproj_pkg::RegRow0C01, coef_pair(f, 0));
    write_reg(pproj_pkg::RegRow0C23,
              coef_pair(cx, $urandom_range(0, 1) ? 32'sd0 : 32'sd65536));
    write_reg(pproj_pkg::RegRow1C01, coef_pair(0, f));
    write_reg(pproj_pkg::RegRow1C23, coef_pair(cy, 0));
    write_reg(pproj_pkg::RegRow2C01, coef_pair(0, 0));
    write_reg(pproj_pkg::RegRow2C23, coef_pair(flip_depth ? -65536 : 65536, 0));
  endtask

  // A point near the camera axis, so that most of these land inside the image.
  function automatic pproj_pkg::point_t camera_point();
    pproj_pkg::point_t pt;
    int zq;
    zq = $urandom_range(1, 60) * 65536 + $urandom_range(0, 65535);
    pt.point_z = zq;
    pt.point_x = $signed($urandom_range(0, 131072)) - 65536;
    pt.point_y = $signed($urandom_range(0, 131072)) - 65536;
    pt.point_x = 32'((longint'(pt.point_x) * zq) >>> 17);
    pt.point_y = 32'((longint'(pt.point_y) * zq) >>> 17);
    pt.reflectance = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
    return pt;
  endfunction

  function automatic pproj_pkg::point_t noise_point();
    pproj_pkg::point_t pt;
    pt.point_x = $urandom;
    pt.point_y = $urandom;
    pt.point_z = $urandom;
    pt.reflectance = 16'($urandom);
    return pt;
  endfunction

  initial begin
    pproj_pkg::point_t pt;
    int unsigned phase_points;
    int f;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset matrix: every divisor is zero, so nothing hits.
    send_point('{point_x: 32'sh7fffffff, point_y: 32'sh80000000, point_z: 32'sd65536,
                 reflectance: 16'hffff}, 1'b0);
    drain_pipeline();

    // Camera with focal length 700 and principal point near the image center.
    load_camera(700 <<< 16, 621 <<< 16, 187 <<< 16, 1'b0);
    // Straight ahead: u=621 or 622 (random row-0 offset), v=187, a hit with full reflectance.
    send_point('{point_x: 0, point_y: 0, point_z: 32'sd65536, reflectance: 16'hffff}, 1'b0);
    // Zero reflectance on a point that would otherwise hit.
    send_point('{point_x: 0, point_y: 0, point_z: 32'sd65536, reflectance: 16'h0000}, 1'b1);
    // Minimum reflectance still counts as a hit.
    send_point('{point_x: 0, point_y: 0, point_z: 32'sd131072, reflectance: 16'h0001}, 1'b1);
    // Zero depth gives a zero divisor.
    send_point('{point_x: 32'sd65536, point_y: 0, point_z: 0, reflectance: 16'h8000}, 1'b0);
    // Far to the left: negative first value.
    send_point('{point_x: -32'sd6553600, point_y: 0, point_z: 32'sd65536,
                 reflectance: 16'h1234}, 1'b0);
    // Extremes of every coordinate field.
    send_point('{point_x: 32'sh80000000, point_y: 32'sh7fffffff, point_z: 32'sh7fffffff,
                 reflectance: 16'h00ff}, 1'b1);
    send_point('{point_x: 32'sh7fffffff, point_y: 32'sh80000000, point_z: 32'sh80000000,
                 reflectance: 16'hff00}, 1'b1);
    send_point('{point_x: -32'sd1, point_y: -32'sd1, point_z: -32'sd1,
                 reflectance: 16'hffff}, 1'b0);
    drain_pipeline();

    // Behind the camera: negative depth rows with negative points.
    load_camera(700 <<< 16, 621 <<< 16, 187 <<< 16, 1'b1);
    send_point('{point_x: 0, point_y: 0, point_z: -32'sd65536, reflectance: 16'h7777}, 1'b0);
    send_point('{point_x: -32'sd100, point_y: -32'sd100, point_z: 32'sd65536,
                 reflectance: 16'h7777}, 1'b0);
    drain_pipeline();

    // Principal point at zero: tiny negative quotients round to column or row zero.
    load_camera(1 <<< 16, 0, 0, 1'b0);
    write_reg(pproj_pkg::RegWidth, 64'd1);
    write_reg(pproj_pkg::RegHeight, 64'd1);
    send_point('{point_x: 0, point_y: -32'sd16000, point_z: 32'sd65536,
                 reflectance: 16'h4000}, 1'b0);
    send_point('{point_x: 0, point_y: -32'sd40000, point_z: 32'sd65536,
                 reflectance: 16'h4000}, 1'b0);
    send_point('{point_x: 32'sd40000, point_y: 0, point_z: 32'sd65536,
                 reflectance: 16'h4000}, 1'b0);
    drain_pipeline();

    // Zero image size: everything misses.
    write_reg(pproj_pkg::RegWidth, 64'd0);
    write_reg(pproj_pkg::RegHeight, 64'd0);
    send_point('{point_x: 0, point_y: 0, point_z: 32'sd65536, reflectance: 16'hffff}, 1'b0);
    drain_pipeline();

    // Random part: a mix of camera setups and image sizes, including oversized ones.
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 5)
        0: f = 700;
        1: f = 2000;
        2: f = 1;
        3: f = 4000;
        default: f = $urandom_range(1, 3000);
      endcase
      load_camera(f <<< 16, $urandom_range(0, 4095) <<< 16,
                  $urandom_range(0, 4095) <<< 16, ph == 7);
      case (ph % 4)
        0: write_reg(pproj_pkg::RegWidth, 64'd8191);
        1: write_reg(pproj_pkg::RegWidth, 64'd4096);
        2: write_reg(pproj_pkg::RegWidth, 64'($urandom_range(1, 4097)));
        default: write_reg(pproj_pkg::RegWidth, 64'd4095);
      endcase
      case (ph % 3)
        0: write_reg(pproj_pkg::RegHeight, 64'd4096);
        1: write_reg(pproj_pkg::RegHeight, 64'd8191);
        default: write_reg(pproj_pkg::RegHeight, 64'($urandom_range(1, 4200)));
      endcase
      if (ph == 11) begin
        // Fully random matrix coefficients to toggle every register bit.
        for (int r = 0; r < pproj_pkg::NumCoefRegs; r++) begin
          write_reg(r[pproj_pkg::CfgIdxW-1:0], {$urandom, $urandom});
        end
      end
      phase_points = RandomPoints / 13;
      for (int n = 0; n < phase_points; n++) begin
        pt = ($urandom_range(0, 9) < 8) ? camera_point() : noise_point();
        send_point(pt, (n / 40) % 3 == 1);
      end
      drain_pipeline();
    end

    if (pixel_sb.mismatches == 0) begin
      $display("point_to_pixel_projection_top_tb passed");
    end else begin
      $display("point_to_pixel_projection_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pproj_pkg.sv
rtl/pproj_if.sv
rtl/pproj_div.sv
rtl/point_to_pixel_projection_top.sv
rtl/pproj_checker.sv
sim/point_to_pixel_projection_top_tb.sv
